### sv/rdb_pkg.sv
// Package for the reversible deque buffer: action codes, port field widths
// and the status word passed from the control logic to the result stage.
// No dependencies.
`default_nettype none

package rdb_pkg;

    // Fixed widths of the item fields on the channels
    localparam int ACTION_W = 3;
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 5;

    // Request codes; the three unused codes are ignored
    typedef enum logic [ACTION_W-1:0] {
        ACT_APPEND  = 3'd0,
        ACT_INSERT  = 3'd1,
        ACT_REMOVE  = 3'd2,
        ACT_PEEK    = 3'd3,
        ACT_REVERSE = 3'd4
    } rdb_action_t;

    // Per-item status computed with the request
    typedef struct packed {
        logic               success;
        logic               is_empty;
        logic [COUNT_W-1:0] entry_count;
    } rdb_status_t;

endpackage

`default_nettype wire

### sv/rdb_req_if.sv
// Request channel of the reversible deque buffer: valid/ready plus the
// action code and entry value. Depends on rdb_pkg.
`default_nettype none

interface rdb_req_if;
    logic                        valid;
    logic                        ready;
    logic [rdb_pkg::ACTION_W-1:0] action;
    logic [rdb_pkg::VALUE_W-1:0]  entry_value;

    modport source (output valid, output action, output entry_value, input ready);
    modport sink   (input valid, input action, input entry_value, output ready);
endinterface

`default_nettype wire

### sv/rdb_rsp_if.sv
// Result channel of the reversible deque buffer: valid/ready plus success,
// front entry, count and empty flag. Depends on rdb_pkg.
`default_nettype none

interface rdb_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        success;
    logic [rdb_pkg::VALUE_W-1:0]  front_value;
    logic [rdb_pkg::COUNT_W-1:0]  entry_count;
    logic                        is_empty;

    modport source (output valid, output success, output front_value,
                    output entry_count, output is_empty, input ready);
    modport sink   (input valid, input success, input front_value,
                    input entry_count, input is_empty, output ready);
endinterface

`default_nettype wire

### sv/reversible_deque_buffer_top.sv
// Reversible deque buffer, top level: pointer control, slot store and the
// result register. Depends on rdb_pkg, rdb_req_if, rdb_rsp_if, rdb_ctrl, rdb_mem.
//
// A bounded double-ended queue of DEPTH entries. Each request item (append,
// front insert, remove, peek, reverse) gives one result item in the cycle after
// it is accepted, so the block sustains one item per clock while results are
// taken. The result sits in an output register; a new request is taken whenever
// that register is empty or its result is being taken in the same cycle. The
// front entry of the result comes from the slot store's single read port, whose
// registered read data forms part of the result register. The store needs no
// clearing after reset: only written slots are ever shown.
`default_nettype none

module reversible_deque_buffer_top #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    rdb_req_if.sink    req,
    rdb_rsp_if.source  rsp
);

    localparam int PW = $clog2(DEPTH);

    logic                  accept;
    logic                  rsp_valid_reg;
    logic                  wr_en;
    logic [PW-1:0]         wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    logic [PW-1:0]         rd_addr;
    logic [DATA_WIDTH-1:0] rd_data;
    logic [DATA_WIDTH+rdb_pkg::VALUE_W-1:0] rd_ext;
    rdb_pkg::rdb_status_t  status;
    rdb_pkg::rdb_status_t  status_reg;

    // Take a request when the result register is free or draining
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    rdb_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .action      (req.action),
        .entry_value (req.entry_value),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .rd_addr     (rd_addr),
        .status      (status)
    );

    rdb_mem #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    // Result status, loaded with each accepted item
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status;
        end
    end

    // Front entry is zero when the queue is empty
    assign rd_ext = {{rdb_pkg::VALUE_W{1'b0}}, rd_data};

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.success     = status_reg.success;
    assign rsp.entry_count = status_reg.entry_count;
    assign rsp.is_empty    = status_reg.is_empty;
    assign rsp.front_value = status_reg.is_empty ? '0 : rd_ext[rdb_pkg::VALUE_W-1:0];

endmodule

`default_nettype wire

### sv/rdb_ctrl.sv
// Pointer control of the reversible deque buffer: front slot, entry count
// and direction flag, plus the slot store write and read addresses.
// Depends on rdb_pkg.
`default_nettype none

module rdb_ctrl #(
    parameter  int DEPTH      = 16,
    parameter  int DATA_WIDTH = 32,
    localparam int PW         = $clog2(DEPTH),
    localparam int CW         = $clog2(DEPTH + 1)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          accept,
    input  wire logic [rdb_pkg::ACTION_W-1:0]  action,
    input  wire logic [rdb_pkg::VALUE_W-1:0]   entry_value,
    output logic                               wr_en,
    output logic [PW-1:0]                      wr_addr,
    output logic [DATA_WIDTH-1:0]              wr_data,
    output logic [PW-1:0]                      rd_addr,
    output rdb_pkg::rdb_status_t               status
);

    logic [PW-1:0] front_reg, front_next;
    logic [CW-1:0] count_reg, count_next;
    logic          flag_reg, flag_next;
    logic          ok;
    logic          not_empty, not_full;
    rdb_pkg::rdb_action_t act;
    logic [DATA_WIDTH+rdb_pkg::VALUE_W-1:0] value_ext;
    logic [CW+rdb_pkg::COUNT_W-1:0]         count_ext;

    // Slot that lies steps logical places from base, going up or down
    function automatic logic [PW-1:0] slot_at(input logic [PW-1:0] base,
                                              input logic [CW-1:0] steps,
                                              input logic rev);
        logic [PW:0] b;
        logic [PW:0] d;
        logic [PW:0] span;
        logic [PW:0] fwd;
        logic [PW:0] bwd;
        b    = {1'b0, base};
        d    = (PW+1)'(steps);
        span = (PW+1)'(DEPTH);
        fwd  = b + d;
        if (fwd >= span)
        begin
            fwd = fwd - span;
        end
        bwd = (b >= d) ? (b - d) : (b + span - d);
        return rev ? bwd[PW-1:0] : fwd[PW-1:0];
    endfunction

    assign act       = rdb_pkg::rdb_action_t'(action);
    assign not_empty = (count_reg != '0);
    assign not_full  = (count_reg != CW'(DEPTH));

    // Keep the low DATA_WIDTH bits of the entry, zero-filled when wider
    assign value_ext = {{DATA_WIDTH{1'b0}}, entry_value};
    assign wr_data   = value_ext[DATA_WIDTH-1:0];

    // Next pointer state for the request
    always_comb
    begin
        front_next = front_reg;
        count_next = count_reg;
        flag_next  = flag_reg;
        ok         = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = slot_at(front_reg, count_reg, flag_reg);
        unique case (act)
            rdb_pkg::ACT_APPEND:
            begin
                if (not_full)
                begin
                    wr_en      = accept;
                    count_next = count_reg + CW'(1);
                    ok         = 1'b1;
                end
            end
            rdb_pkg::ACT_INSERT:
            begin
                // front insert is ignored on an empty queue
                if (not_empty && not_full)
                begin
                    front_next = slot_at(front_reg, CW'(1), !flag_reg);
                    wr_en      = accept;
                    wr_addr    = front_next;
                    count_next = count_reg + CW'(1);
                    ok         = 1'b1;
                end
            end
            rdb_pkg::ACT_REMOVE:
            begin
                if (not_empty)
                begin
                    front_next = slot_at(front_reg, CW'(1), flag_reg);
                    count_next = count_reg - CW'(1);
                    ok         = 1'b1;
                end
            end
            rdb_pkg::ACT_PEEK:
            begin
                ok = not_empty;
            end
            rdb_pkg::ACT_REVERSE:
            begin
                // old back entry becomes the front, direction flips
                if (not_empty)
                begin
                    front_next = slot_at(front_reg, count_reg - CW'(1), flag_reg);
                    flag_next  = !flag_reg;
                    ok         = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Front entry after the request is read back for the result
    assign rd_addr   = front_next;
    assign count_ext = {{rdb_pkg::COUNT_W{1'b0}}, count_next};

    assign status.success     = ok;
    assign status.is_empty    = (count_next == '0);
    assign status.entry_count = count_ext[rdb_pkg::COUNT_W-1:0];

    // Pointer state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            count_reg <= '0;
            flag_reg  <= 1'b0;
        end
        else if (accept)
        begin
            front_reg <= front_next;
            count_reg <= count_next;
            flag_reg  <= flag_next;
        end
    end

endmodule

`default_nettype wire

### sv/rdb_mem.sv
// Slot store of the reversible deque buffer: one write port and one read
// port with registered read data and write-to-read forwarding. No dependencies.
`default_nettype none

module rdb_mem #(
    parameter  int DEPTH      = 16,
    parameter  int DATA_WIDTH = 32,
    localparam int PW         = $clog2(DEPTH)
) (
    input  wire logic                  clk,
    input  wire logic                  wr_en,
    input  wire logic [PW-1:0]         wr_addr,
    input  wire logic [DATA_WIDTH-1:0] wr_data,
    input  wire logic                  rd_en,
    input  wire logic [PW-1:0]         rd_addr,
    output logic [DATA_WIDTH-1:0]      rd_data
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; an entry written in the same cycle is forwarded
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_data_reg <= wr_data;
            end
            else
            begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### sv/rdb_checker.sv
// Port checker for the reversible deque buffer and its bind to the top level.
// Depends on rdb_pkg and reversible_deque_buffer_top.
`default_nettype none

module rdb_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         req_valid,
    input wire logic                         req_ready,
    input wire logic                         rsp_valid,
    input wire logic                         rsp_ready,
    input wire logic                         rsp_success,
    input wire logic [rdb_pkg::VALUE_W-1:0]  rsp_front_value,
    input wire logic [rdb_pkg::COUNT_W-1:0]  rsp_entry_count,
    input wire logic                         rsp_is_empty
);

    // Stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_success)
            && $stable(rsp_front_value) && $stable(rsp_entry_count)
            && $stable(rsp_is_empty))
        else $error("result changed while stalled");

    // Every accepted item produces a result next cycle
    a_item_result: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> rsp_valid)
        else $error("accepted item gave no result");

    // No item taken while a stalled result would be overwritten
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |-> !req_ready)
        else $error("request taken over a pending result");

    // Empty queue shows zero count and zero front entry
    a_empty_view: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_is_empty |-> rsp_entry_count == '0 && rsp_front_value == '0)
        else $error("empty result with nonzero count or entry");

endmodule

bind reversible_deque_buffer_top rdb_checker u_rdb_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_success     (rsp.success),
    .rsp_front_value (rsp.front_value),
    .rsp_entry_count (rsp.entry_count),
    .rsp_is_empty    (rsp.is_empty)
);

`default_nettype wire
